/* sv/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types, codes and helpers of the serial-line CAN command decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

    localparam int STD_ID_DIGITS  = 3;
    localparam int EXT_ID_DIGITS  = 8;
    localparam int MAX_DATA_BYTES = 8;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 5;
    localparam int KIND_W  = 3;
    localparam int RATE_W  = 2;
    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int LANES   = DATA_W / 8;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RATE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TX    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    // Command letters
    localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h4F; // 'O'
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h43; // 'C'
    localparam logic [CHAR_W-1:0] CH_RATE    = 8'h53; // 'S'
    localparam logic [CHAR_W-1:0] CH_TX_STD  = 8'h74; // 't'
    localparam logic [CHAR_W-1:0] CH_TX_EXT  = 8'h54; // 'T'
    localparam logic [CHAR_W-1:0] CH_RTR_STD = 8'h72; // 'r'
    localparam logic [CHAR_W-1:0] CH_RTR_EXT = 8'h52; // 'R'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41; // 'A'

    localparam logic [CHAR_W-1:0] DIGIT_OFS  = 8'h30;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'h37;

    localparam logic [CHAR_W-1:0] MAX_RATE = 8'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } t_char_req;

    typedef struct packed {
        logic [KIND_W-1:0] command_kind;
        logic [RATE_W-1:0] bitrate_code;
        logic              extended_id;
        logic              remote_frame;
        logic [ID_W-1:0]   identifier;
        logic [LEN_W-1:0]  length_code;
        logic [DATA_W-1:0] payload;
    } t_result;

    function automatic logic [CHAR_W-1:0] to_digit(input logic [CHAR_W-1:0] c);
        return (c < CH_UPPER_A) ? c - DIGIT_OFS : c - LETTER_OFS;
    endfunction

endpackage

`default_nettype wire

/* sv/slcd_in_stage.sv */
// ----------------------------------------------------------------------------
// slcd_in_stage
// Input register for incoming characters; holds a request until the parser
// takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcd_in_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire slcd_pkg::t_char_req i_req,
    input  wire logic                i_take,
    output logic                     o_valid,
    output slcd_pkg::t_char_req      o_req
);

    logic                r_valid;
    slcd_pkg::t_char_req r_req;
    logic                accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

/* sv/slcd_line_parser.sv */
// ----------------------------------------------------------------------------
// slcd_line_parser
// Per-line state and single-pass decode: folds each character into the
// position-indexed registers and forms the command on the last character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcd_line_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire slcd_pkg::t_char_req i_req,
    output slcd_pkg::t_result        o_result
);

    logic [slcd_pkg::POS_W-1:0]  r_pos,    n_pos;
    logic [slcd_pkg::CHAR_W-1:0] r_letter, n_letter;
    logic [slcd_pkg::ID_W-1:0]   r_id,     n_id;
    logic [slcd_pkg::CHAR_W-1:0] r_len,    n_len;
    logic [slcd_pkg::CHAR_W-1:0] r_rate,   n_rate;
    logic [slcd_pkg::DATA_W-1:0] r_data,   n_data;

    logic                        is_ext;
    logic                        is_tx;
    logic                        is_rtr;
    logic [slcd_pkg::POS_W-1:0]  id_len;
    logic [slcd_pkg::POS_W-1:0]  id_back;
    logic [slcd_pkg::POS_W-1:0]  id_shift;
    logic [slcd_pkg::POS_W-1:0]  data_k;
    logic [slcd_pkg::CHAR_W-1:0] digit;
    logic [slcd_pkg::CHAR_W-1:0] nib;
    logic                        in_data;
    logic [slcd_pkg::DATA_W-1:0] pay_mask;
    slcd_pkg::t_result           res;

    always_comb begin
        digit    = slcd_pkg::to_digit(i_req.char_in);
        n_letter = (r_pos == '0) ? i_req.char_in : r_letter;
        is_ext   = (n_letter == slcd_pkg::CH_TX_EXT) || (n_letter == slcd_pkg::CH_RTR_EXT);
        is_rtr   = (n_letter == slcd_pkg::CH_RTR_STD) || (n_letter == slcd_pkg::CH_RTR_EXT);
        is_tx    = is_ext || is_rtr || (n_letter == slcd_pkg::CH_TX_STD);
        id_len   = is_ext ? slcd_pkg::POS_W'(slcd_pkg::EXT_ID_DIGITS)
                          : slcd_pkg::POS_W'(slcd_pkg::STD_ID_DIGITS);
        id_back  = id_len - r_pos;
        id_shift = {id_back[2:0], 2'b00};
        data_k   = r_pos - id_len - slcd_pkg::POS_W'(2);
        in_data  = (r_pos >= id_len + slcd_pkg::POS_W'(2))
                && (data_k < slcd_pkg::POS_W'(2 * slcd_pkg::MAX_DATA_BYTES));
        // high digit of a byte lands in the upper nibble
        nib      = data_k[0] ? digit : {digit[3:0], 4'h0};

        n_rate = (r_pos == slcd_pkg::POS_W'(1)) ? digit : r_rate;

        n_id = r_id;
        if (r_pos != '0 && r_pos <= id_len) begin
            n_id = r_id + (slcd_pkg::ID_W'(digit) << id_shift);
        end

        n_len = (r_pos != '0 && r_pos == id_len + slcd_pkg::POS_W'(1)) ? digit : r_len;

        n_data = r_data;
        for (int i = 0; i < slcd_pkg::LANES; i++) begin
            if (in_data && data_k[3:1] == 3'(i)) begin
                n_data[slcd_pkg::DATA_W-1-8*i -: 8] =
                    r_data[slcd_pkg::DATA_W-1-8*i -: 8] + nib;
            end
        end

        n_pos = (r_pos == slcd_pkg::POS_MAX) ? r_pos : r_pos + slcd_pkg::POS_W'(1);

        // keep only bytes below the length code
        for (int i = 0; i < slcd_pkg::LANES; i++) begin
            pay_mask[slcd_pkg::DATA_W-1-8*i -: 8] =
                (slcd_pkg::CHAR_W'(i) < n_len) ? 8'hFF : 8'h00;
        end

        res = '0;
        unique case (n_letter)
            slcd_pkg::CH_OPEN: begin
                res.command_kind = slcd_pkg::KIND_OPEN;
            end
            slcd_pkg::CH_CLOSE: begin
                res.command_kind = slcd_pkg::KIND_CLOSE;
            end
            slcd_pkg::CH_RATE: begin
                if (n_rate <= slcd_pkg::MAX_RATE) begin
                    res.command_kind = slcd_pkg::KIND_RATE;
                    res.bitrate_code = n_rate[slcd_pkg::RATE_W-1:0];
                end else begin
                    res.command_kind = slcd_pkg::KIND_ERROR;
                end
            end
            default: begin
                if (is_tx && n_len <= slcd_pkg::CHAR_W'(slcd_pkg::MAX_DATA_BYTES)) begin
                    res.command_kind = slcd_pkg::KIND_TX;
                    res.extended_id  = is_ext;
                    res.remote_frame = is_rtr;
                    res.identifier   = n_id;
                    res.length_code  = n_len[slcd_pkg::LEN_W-1:0];
                    res.payload      = n_data & pay_mask;
                end else begin
                    res.command_kind = slcd_pkg::KIND_ERROR;
                end
            end
        endcase
    end

    // clear the line state after its last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_letter <= '0;
            r_id     <= '0;
            r_len    <= '0;
            r_rate   <= '0;
            r_data   <= '0;
        end else if (i_en) begin
            if (i_req.last_char) begin
                r_pos    <= '0;
                r_letter <= '0;
                r_id     <= '0;
                r_len    <= '0;
                r_rate   <= '0;
                r_data   <= '0;
            end else begin
                r_pos    <= n_pos;
                r_letter <= n_letter;
                r_id     <= n_id;
                r_len    <= n_len;
                r_rate   <= n_rate;
                r_data   <= n_data;
            end
        end
    end

    assign o_result = res;

`ifndef NO_ASSERTIONS
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.last_char |=> r_pos == '0 && r_letter == '0)
        else $error("line state not cleared after last character");

    a_non_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.command_kind != slcd_pkg::KIND_TX |->
            res.identifier == '0 && res.payload == '0 && res.length_code == '0
            && !res.extended_id && !res.remote_frame)
        else $error("frame fields set on a non-transmit command");

    a_tx_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.command_kind == slcd_pkg::KIND_TX |->
            res.length_code <= slcd_pkg::LEN_W'(slcd_pkg::MAX_DATA_BYTES))
        else $error("transmit with length code out of range");
`endif

endmodule

`default_nettype wire

/* sv/slcd_out_stage.sv */
// ----------------------------------------------------------------------------
// slcd_out_stage
// Result register: holds a decoded command until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcd_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire slcd_pkg::t_result i_result,
    output logic                   o_busy,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output slcd_pkg::t_result      o_result
);

    logic              r_valid;
    slcd_pkg::t_result r_result;

    assign o_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* sv/slcan_command_line_decoder_unit.sv */
// ----------------------------------------------------------------------------
// slcan_command_line_decoder_unit
// Serial-line CAN ASCII command decoder: one character per request, one
// decoded command per line.
// ----------------------------------------------------------------------------
// Characters of a command line enter one per clock unless input stalls;
// i_last_char marks the end of the line. A character passes an input
// register, then is folded into the line state in a single pass, so a new
// character is taken every cycle while input does not stall. On the last
// character the decoded command (open, close, set bitrate, transmit or
// error) is loaded into the result register. No gap is needed between
// lines; input only stalls when a finished command sits unclaimed in the
// result register and another last character is waiting behind it.
`timescale 1ns / 1ps
`default_nettype none

module slcan_command_line_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_last_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_command_kind,
    output logic [1:0]       o_bitrate_code,
    output logic             o_extended_id,
    output logic             o_remote_frame,
    output logic [28:0]      o_identifier,
    output logic [3:0]       o_length_code,
    output logic [63:0]      o_payload
);

    slcd_pkg::t_char_req in_req;
    slcd_pkg::t_char_req cur_req;
    slcd_pkg::t_result   dec_result;
    slcd_pkg::t_result   out_result;
    logic                cur_valid;
    logic                out_busy;
    logic                take;

    assign in_req.char_in   = i_char_in;
    assign in_req.last_char = i_last_char;

    // advance unless a last character would overwrite an unclaimed result
    assign take = cur_valid && !(cur_req.last_char && out_busy);

    slcd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (in_req),
        .i_take  (take),
        .o_valid (cur_valid),
        .o_req   (cur_req)
    );

    slcd_line_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (take),
        .i_req    (cur_req),
        .o_result (dec_result)
    );

    slcd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && cur_req.last_char),
        .i_result (dec_result),
        .o_busy   (out_busy),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_command_kind = out_result.command_kind;
    assign o_bitrate_code = out_result.bitrate_code;
    assign o_extended_id  = out_result.extended_id;
    assign o_remote_frame = out_result.remote_frame;
    assign o_identifier   = out_result.identifier;
    assign o_length_code  = out_result.length_code;
    assign o_payload      = out_result.payload;

endmodule

`default_nettype wire
